### src/lease_slot_table_assert.svh
// Assertion macros shared by the lease slot table RTL.
`ifndef LEASE_SLOT_TABLE_ASSERT_SVH
`define LEASE_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/lst_pkg.sv
// Package with the widths, codes and entry layout of the lease slot table.
package lst_pkg;

  // Default table size.
  localparam int NUM_SLOTS_DEF = 16;

  // Field widths of items and results.
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 4;
  localparam int OWNER_W  = 64;
  localparam int TIME_W   = 64;
  localparam int COLOUR_W = 8;
  localparam int STYLE_W  = 6;
  localparam int STATUS_W = 2;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_RECLAIM = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STALE   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RECLAIM_RST = 32'd10000;
  localparam logic [CFG_DATA_W-1:0] STALE_RST   = 32'd2000;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLAIM   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUBLISH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLASH   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OWNER_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

  // One table entry as it is stored in memory.
  typedef struct packed {
    logic [OWNER_W-1:0]  owner;
    logic [TIME_W-1:0]   heartbeat;
    logic [COLOUR_W-1:0] colour;
    logic [STYLE_W-1:0]  style;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

endpackage

### src/lst_in_if.sv
// Input channel of the lease slot table: one command item per handshake.
interface lst_in_if;
  logic                         valid;
  logic                         ready;
  logic [lst_pkg::CMD_W-1:0]    cmd;
  logic [lst_pkg::IDX_W-1:0]    slot_index;
  logic [lst_pkg::OWNER_W-1:0]  owner_id;
  logic [lst_pkg::TIME_W-1:0]   now_ms;
  logic [lst_pkg::COLOUR_W-1:0] colour;
  logic [lst_pkg::STYLE_W-1:0]  style;

  modport source (output valid, cmd, slot_index, owner_id, now_ms, colour, style,
                  input ready);
  modport sink (input valid, cmd, slot_index, owner_id, now_ms, colour, style,
                output ready);
endinterface

### src/lst_out_if.sv
// Result channel of the lease slot table: one result item per handshake.
interface lst_out_if;
  logic                         valid;
  logic                         ready;
  logic [lst_pkg::STATUS_W-1:0] status;
  logic [lst_pkg::IDX_W-1:0]    slot_out;
  logic [lst_pkg::OWNER_W-1:0]  owner_out;
  logic [lst_pkg::COLOUR_W-1:0] colour_out;
  logic [lst_pkg::STYLE_W-1:0]  style_out;
  logic                         live;
  logic                         clash;

  modport source (output valid, status, slot_out, owner_out, colour_out, style_out, live,
                  clash, input ready);
  modport sink (input valid, status, slot_out, owner_out, colour_out, style_out, live,
                clash, output ready);
endinterface

### src/lease_slot_table.sv
// Lease slot table: owner leases with heartbeats, kept in one entry memory.
// The table holds NUM_SLOTS leases, one memory word per slot (owner, heartbeat, colour,
// style), read through a registered read port; a valid bit per slot makes an unwritten
// slot read as free with all fields zero, so no clearing pass follows reset. One item is
// worked on at a time. Claims and clash checks walk the memory one slot per cycle over the
// slots below a limit that is NUM_SLOTS for a claim and, for a clash check, the addressed
// slot index (NUM_SLOTS when it lies beyond the table); a clash check at slot zero reads
// nothing. Release, publish and read take one memory read; a claim with owner id zero and
// an unknown command read no memory. The result waits in an output register, and the next
// item is accepted while it waits. Configuration registers (index 0 reclaim limit,
// index 1 stale limit) are written with cfg_we.
module lease_slot_table #(
  parameter int NUM_SLOTS = lst_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lst_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  lst_in_if.sink                           in_ch,
  lst_out_if.source                        out_ch
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [lst_pkg::CFG_DATA_W-1:0] reclaim_r, reclaim_nxt;
  logic [lst_pkg::CFG_DATA_W-1:0] stale_r, stale_nxt;

  // Latched item.
  logic [lst_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic                         in_range_r, in_range_nxt;
  logic [lst_pkg::OWNER_W-1:0]  owner_r, owner_nxt;
  logic [lst_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [lst_pkg::COLOUR_W-1:0] colour_r, colour_nxt;
  logic [lst_pkg::STYLE_W-1:0]  style_r, style_nxt;
  logic [CW-1:0]                lim_r, lim_nxt;

  // Scan state.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic          found_free_r, found_free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          found_recl_r, found_recl_nxt;
  logic [IW-1:0] recl_idx_r, recl_idx_nxt;
  logic          clash_r, clash_nxt;

  // Pending result and its memory write.
  logic [lst_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [lst_pkg::IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic [lst_pkg::OWNER_W-1:0]  res_owner_r, res_owner_nxt;
  logic [lst_pkg::COLOUR_W-1:0] res_colour_r, res_colour_nxt;
  logic [lst_pkg::STYLE_W-1:0]  res_style_r, res_style_nxt;
  logic                         res_live_r, res_live_nxt;
  logic                         res_clash_r, res_clash_nxt;
  logic                         wr_en_r, wr_en_nxt;
  logic [IW-1:0]                wr_addr_r, wr_addr_nxt;
  lst_pkg::entry_t              wr_data_r, wr_data_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [lst_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [lst_pkg::IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic [lst_pkg::OWNER_W-1:0]  out_owner_r, out_owner_nxt;
  logic [lst_pkg::COLOUR_W-1:0] out_colour_r, out_colour_nxt;
  logic [lst_pkg::STYLE_W-1:0]  out_style_r, out_style_nxt;
  logic                         out_live_r, out_live_nxt;
  logic                         out_clash_r, out_clash_nxt;

  // Slot valid bits and the valid bit of the word being read.
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic                 rd_valid_r, rd_valid_nxt;

  // Memory port signals.
  logic            ram_we;
  logic            ram_re;
  logic [IW-1:0]   ram_raddr;
  logic [lst_pkg::ENT_W-1:0] ram_q;
  logic            out_load;

  // Entry evaluation.
  lst_pkg::entry_t           ent;
  logic [lst_pkg::TIME_W:0]  diff;
  logic [lst_pkg::TIME_W-1:0] age;
  logic                      ent_live;
  logic                      ent_recl;
  logic                      ent_match;

  // Index conversions.
  logic [IW+lst_pkg::IDX_W-1:0] in_idx_wide;
  logic [CW+lst_pkg::IDX_W-1:0] in_idx_cw;
  logic                         in_range_in;
  logic [IW-1:0]                pick;
  logic [IW+lst_pkg::IDX_W-1:0] pick_wide;

  lst_ram #(
    .WIDTH (lst_pkg::ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (wr_data_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Slot index of the incoming item, sized for addressing and for the scan limit.
  assign in_idx_wide = (IW + lst_pkg::IDX_W)'(in_ch.slot_index);
  assign in_idx_cw   = (CW + lst_pkg::IDX_W)'(in_ch.slot_index);
  assign in_range_in = in_idx_cw < (CW + lst_pkg::IDX_W)'(NUM_SLOTS);

  // Entry just read; a slot never written reads as all zero.
  assign ent  = rd_valid_r ? lst_pkg::entry_t'(ram_q) : '0;
  assign diff = {1'b0, now_r} - {1'b0, ent.heartbeat};
  assign age  = diff[lst_pkg::TIME_W] ? '0 : diff[lst_pkg::TIME_W-1:0];
  assign ent_live = (ent.owner != '0) && (ent.heartbeat != '0) &&
                    (age <= lst_pkg::TIME_W'(stale_r));
  assign ent_recl = (ent.owner != '0) && (age > lst_pkg::TIME_W'(reclaim_r));
  assign ent_match = ent_live && (ent.colour == colour_r) && (ent.style == style_r);

  // Slot granted by a claim: the lowest free one, else the lowest reclaimable one.
  assign pick      = found_free_r ? free_idx_r : recl_idx_r;
  assign pick_wide = (IW + lst_pkg::IDX_W)'(pick);

  // Sequencer and datapath.
  always_comb begin
    state_nxt      = state_r;
    reclaim_nxt    = reclaim_r;
    stale_nxt      = stale_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    in_range_nxt   = in_range_r;
    owner_nxt      = owner_r;
    now_nxt        = now_r;
    colour_nxt     = colour_r;
    style_nxt      = style_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    found_free_nxt = found_free_r;
    free_idx_nxt   = free_idx_r;
    found_recl_nxt = found_recl_r;
    recl_idx_nxt   = recl_idx_r;
    clash_nxt      = clash_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_owner_nxt  = res_owner_r;
    res_colour_nxt = res_colour_r;
    res_style_nxt  = res_style_r;
    res_live_nxt   = res_live_r;
    res_clash_nxt  = res_clash_r;
    wr_en_nxt      = wr_en_r;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[IW-1:0];
    out_load       = 1'b0;

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_addr)
        lst_pkg::CFG_RECLAIM: reclaim_nxt = cfg_wdata;
        lst_pkg::CFG_STALE:   stale_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt        = in_ch.cmd;
          idx_nxt        = in_idx_wide[IW-1:0];
          in_range_nxt   = in_range_in;
          owner_nxt      = in_ch.owner_id;
          now_nxt        = in_ch.now_ms;
          colour_nxt     = in_ch.colour;
          style_nxt      = in_ch.style;
          cnt_nxt        = '0;
          pend_nxt       = 1'b0;
          found_free_nxt = 1'b0;
          found_recl_nxt = 1'b0;
          clash_nxt      = 1'b0;
          wr_en_nxt      = 1'b0;
          res_status_nxt = lst_pkg::ST_OK;
          res_slot_nxt   = in_ch.slot_index;
          res_owner_nxt  = '0;
          res_colour_nxt = '0;
          res_style_nxt  = '0;
          res_live_nxt   = 1'b0;
          res_clash_nxt  = 1'b0;
          case (in_ch.cmd) inside
            lst_pkg::CMD_CLAIM: begin
              res_slot_nxt = '0;
              lim_nxt      = CW'(NUM_SLOTS);
              if (in_ch.owner_id == '0) begin
                res_status_nxt = lst_pkg::ST_OWNER_ZERO;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            lst_pkg::CMD_CLASH: begin
              lim_nxt   = in_range_in ? in_idx_cw[CW-1:0] : CW'(NUM_SLOTS);
              state_nxt = S_SCAN;
            end
            lst_pkg::CMD_RELEASE, lst_pkg::CMD_PUBLISH, lst_pkg::CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = in_idx_wide[IW-1:0];
              state_nxt = S_LOOK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Single-slot commands: the addressed entry is on the read port now.
      S_LOOK: begin
        case (cmd_r)
          lst_pkg::CMD_RELEASE: begin
            if (in_range_r) begin
              wr_en_nxt          = 1'b1;
              wr_addr_nxt        = idx_r;
              wr_data_nxt        = '0;
              wr_data_nxt.colour = ent.colour;
              wr_data_nxt.style  = ent.style;
            end
          end
          lst_pkg::CMD_PUBLISH: begin
            if (in_range_r && (ent.owner != '0)) begin
              wr_en_nxt             = 1'b1;
              wr_addr_nxt           = idx_r;
              wr_data_nxt.owner     = ent.owner;
              wr_data_nxt.heartbeat = now_r;
              wr_data_nxt.colour    = colour_r;
              wr_data_nxt.style     = style_r;
            end
          end
          default: begin
            if (in_range_r) begin
              res_owner_nxt  = ent.owner;
              res_colour_nxt = ent.colour;
              res_style_nxt  = ent.style;
              res_live_nxt   = ent_live;
            end
          end
        endcase
        state_nxt = S_DONE;
      end

      // Scan: issue one read per cycle and evaluate the entry read the cycle before.
      S_SCAN: begin
        if (pend_r) begin
          if (cmd_r == lst_pkg::CMD_CLAIM) begin
            if (!found_free_r && (ent.owner == '0)) begin
              found_free_nxt = 1'b1;
              free_idx_nxt   = pend_idx_r;
            end
            if (!found_recl_r && ent_recl) begin
              found_recl_nxt = 1'b1;
              recl_idx_nxt   = pend_idx_r;
            end
          end else if (ent_match) begin
            clash_nxt = 1'b1;
          end
        end
        if (cnt_r < lim_r) begin
          ram_re       = 1'b1;
          ram_raddr    = cnt_r[IW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (cmd_r == lst_pkg::CMD_CLAIM) begin
              if (found_free_r || found_recl_r) begin
                wr_en_nxt             = 1'b1;
                wr_addr_nxt           = pick;
                wr_data_nxt           = '0;
                wr_data_nxt.owner     = owner_r;
                wr_data_nxt.heartbeat = now_r;
                res_slot_nxt          = pick_wide[lst_pkg::IDX_W-1:0];
              end else begin
                res_status_nxt = lst_pkg::ST_FULL;
              end
            end else begin
              res_clash_nxt = clash_r;
            end
            state_nxt = S_DONE;
          end
        end
      end

      // Once the output register is free, hand the result to it and commit the memory write.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_we = out_load && wr_en_r;

  // Valid bits of the slots and of the word on the read port.
  always_comb begin
    valid_nxt    = valid_r;
    rd_valid_nxt = rd_valid_r;
    if (ram_we) begin
      valid_nxt[wr_addr_r] = 1'b1;
    end
    if (ram_re) begin
      rd_valid_nxt = valid_r[ram_raddr];
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_owner_nxt  = out_owner_r;
    out_colour_nxt = out_colour_r;
    out_style_nxt  = out_style_r;
    out_live_nxt   = out_live_r;
    out_clash_nxt  = out_clash_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_slot_nxt   = res_slot_r;
      out_owner_nxt  = res_owner_r;
      out_colour_nxt = res_colour_r;
      out_style_nxt  = res_style_r;
      out_live_nxt   = res_live_r;
      out_clash_nxt  = res_clash_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reclaim_r   <= lst_pkg::RECLAIM_RST;
      stale_r     <= lst_pkg::STALE_RST;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      wr_en_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reclaim_r   <= reclaim_nxt;
      stale_r     <= stale_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      wr_en_r     <= wr_en_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    in_range_r   <= in_range_nxt;
    owner_r      <= owner_nxt;
    now_r        <= now_nxt;
    colour_r     <= colour_nxt;
    style_r      <= style_nxt;
    lim_r        <= lim_nxt;
    pend_idx_r   <= pend_idx_nxt;
    found_free_r <= found_free_nxt;
    free_idx_r   <= free_idx_nxt;
    found_recl_r <= found_recl_nxt;
    recl_idx_r   <= recl_idx_nxt;
    clash_r      <= clash_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_owner_r  <= res_owner_nxt;
    res_colour_r <= res_colour_nxt;
    res_style_r  <= res_style_nxt;
    res_live_r   <= res_live_nxt;
    res_clash_r  <= res_clash_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_data_r    <= wr_data_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_owner_r  <= out_owner_nxt;
    out_colour_r <= out_colour_nxt;
    out_style_r  <= out_style_nxt;
    out_live_r   <= out_live_nxt;
    out_clash_r  <= out_clash_nxt;
  end

  // Channel ports.
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_out   = out_slot_r;
  assign out_ch.owner_out  = out_owner_r;
  assign out_ch.colour_out = out_colour_r;
  assign out_ch.style_out  = out_style_r;
  assign out_ch.live       = out_live_r;
  assign out_ch.clash      = out_clash_r;

  // Checks.
`include "lease_slot_table_assert.svh"

  `LST_ASSERT_NXT(a_one_item_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "item accepted while busy")
  `LST_ASSERT_IMP(a_scan_in_bounds, state_r == S_SCAN, cnt_r <= lim_r, "scan ran past its limit")
  `LST_ASSERT_IMP(a_claim_writes_owner, ram_we && (cmd_r == lst_pkg::CMD_CLAIM), wr_data_r.owner != '0, "claim wrote a free slot")
  `LST_ASSERT_NXT(a_result_follows_load, out_load, out_ch.valid, "result lost at output register")

endmodule

### src/lst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lst_ram #(
  parameter int WIDTH = lst_pkg::ENT_W,
  parameter int DEPTH = lst_pkg::NUM_SLOTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
